### sv/lwsp_pkg.sv
// ----------------------------------------------------------------------------
// lwsp_pkg
// Types and constants shared by the level window shortest path block.
// ----------------------------------------------------------------------------
`default_nettype none

package lwsp_pkg;

   // request kinds
   localparam logic [1:0] KIND_NODE  = 2'd0;
   localparam logic [1:0] KIND_EDGE  = 2'd1;
   localparam logic [1:0] KIND_SOLVE = 2'd2;
   localparam logic [1:0] KIND_CLEAR = 2'd3;

   // configuration register indexes
   localparam logic CSR_LEVEL_GAP  = 1'b0;
   localparam logic CSR_NODE_COUNT = 1'b1;

   localparam logic [31:0] DIST_INF = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [6:0]  node_index;
      logic [6:0]  from_node;
      logic [15:0] node_level;
      logic [15:0] cost;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] min_cost;
      logic        overflow;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_L1RD, ST_L1CAP, ST_WRD, ST_WCHK, ST_INIT, ST_SCAN, ST_SCANEND,
      ST_PICK, ST_ERD, ST_ETGT, ST_EUPD, ST_RRD, ST_RCAP, ST_WNEXT, ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic best_init;
      logic lvl_rd_one;
      logic l1_cap;
      logic lvl_rd_win;
      logic win_start;
      logic init_wr;
      logic scan_rd;
      logic settle;
      logic edge_rd;
      logic edge_look;
      logic edge_upd;
      logic res_rd;
      logic res_cap;
      logic win_next;
      logic rsp_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_solve;
      logic lim_zero;
      logic win_ok;
      logic cnt_last;
      logic found;
      logic edge_none;
      logic edge_last;
      logic win_last;
      logic rsp_free;
   } status_type;

endpackage

`default_nettype wire

### sv/lwsp_ctrl.sv
// ----------------------------------------------------------------------------
// lwsp_ctrl
// Sequencer for loading, window search and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module lwsp_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  wire lwsp_pkg::status_type status,
   output lwsp_pkg::cmd_type      cmd
);

   lwsp_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lwsp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lwsp_pkg::ST_IDLE: begin
            if (req_valid && status.is_solve) state_in = lwsp_pkg::ST_L1RD;
         end
         lwsp_pkg::ST_L1RD: begin
            state_in = status.lim_zero ? lwsp_pkg::ST_DONE : lwsp_pkg::ST_L1CAP;
         end
         lwsp_pkg::ST_L1CAP: state_in = lwsp_pkg::ST_WRD;
         lwsp_pkg::ST_WRD:   state_in = lwsp_pkg::ST_WCHK;
         lwsp_pkg::ST_WCHK: begin
            state_in = status.win_ok ? lwsp_pkg::ST_INIT : lwsp_pkg::ST_WNEXT;
         end
         lwsp_pkg::ST_INIT: begin
            if (status.cnt_last) state_in = lwsp_pkg::ST_SCAN;
         end
         lwsp_pkg::ST_SCAN: begin
            if (status.cnt_last) state_in = lwsp_pkg::ST_SCANEND;
         end
         lwsp_pkg::ST_SCANEND: state_in = lwsp_pkg::ST_PICK;
         lwsp_pkg::ST_PICK: begin
            if (!status.found) state_in = lwsp_pkg::ST_RRD;
            else if (status.edge_none) state_in = lwsp_pkg::ST_SCAN;
            else state_in = lwsp_pkg::ST_ERD;
         end
         lwsp_pkg::ST_ERD:  state_in = lwsp_pkg::ST_ETGT;
         lwsp_pkg::ST_ETGT: state_in = lwsp_pkg::ST_EUPD;
         lwsp_pkg::ST_EUPD: begin
            state_in = status.edge_last ? lwsp_pkg::ST_SCAN : lwsp_pkg::ST_ERD;
         end
         lwsp_pkg::ST_RRD:  state_in = lwsp_pkg::ST_RCAP;
         lwsp_pkg::ST_RCAP: state_in = lwsp_pkg::ST_WNEXT;
         lwsp_pkg::ST_WNEXT: begin
            state_in = status.win_last ? lwsp_pkg::ST_DONE : lwsp_pkg::ST_WRD;
         end
         lwsp_pkg::ST_DONE: begin
            if (status.rsp_free) state_in = lwsp_pkg::ST_IDLE;
         end
         default: state_in = lwsp_pkg::ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      case (state_ff)
         lwsp_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         lwsp_pkg::ST_L1RD: begin
            cmd.lvl_rd_one = 1'b1;
            cmd.best_init  = 1'b1;
         end
         lwsp_pkg::ST_L1CAP: cmd.l1_cap = 1'b1;
         lwsp_pkg::ST_WRD:   cmd.lvl_rd_win = 1'b1;
         lwsp_pkg::ST_WCHK:  cmd.win_start = status.win_ok;
         lwsp_pkg::ST_INIT:  cmd.init_wr = 1'b1;
         lwsp_pkg::ST_SCAN:  cmd.scan_rd = 1'b1;
         lwsp_pkg::ST_PICK:  cmd.settle = status.found;
         lwsp_pkg::ST_ERD:   cmd.edge_rd = 1'b1;
         lwsp_pkg::ST_ETGT:  cmd.edge_look = 1'b1;
         lwsp_pkg::ST_EUPD:  cmd.edge_upd = 1'b1;
         lwsp_pkg::ST_RRD:   cmd.res_rd = 1'b1;
         lwsp_pkg::ST_RCAP:  cmd.res_cap = 1'b1;
         lwsp_pkg::ST_WNEXT: cmd.win_next = !status.win_last;
         lwsp_pkg::ST_DONE:  cmd.rsp_load = status.rsp_free;
         default: cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

### sv/lwsp_datapath.sv
// ----------------------------------------------------------------------------
// lwsp_datapath
// Graph stores, distance memory, minimum scan and relaxation logic.
// ----------------------------------------------------------------------------
`default_nettype none

module lwsp_datapath #(
   parameter int MAX_NODES = 128,
   parameter int MAX_EDGES = 1024
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire lwsp_pkg::req_payload_type req_payload,
   input  wire                        csr_valid,
   input  wire                        csr_index,
   input  wire  [15:0]                csr_data,
   input  wire lwsp_pkg::cmd_type     cmd,
   output lwsp_pkg::status_type       status,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output lwsp_pkg::rsp_payload_type  rsp_payload
);

   localparam int NW  = $clog2(MAX_NODES);
   localparam int EW  = $clog2(MAX_EDGES);
   localparam int ETW = $clog2(MAX_EDGES + 1);

   // configuration
   logic [15:0] gap_ff;
   logic [6:0]  count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff   <= '0;
         count_ff <= 7'd1;
      end else if (csr_valid) begin
         if (csr_index == lwsp_pkg::CSR_LEVEL_GAP) gap_ff <= csr_data;
         else count_ff <= csr_data[6:0];
      end
   end

   // highest usable node index
   logic [6:0] lim;
   always_comb begin
      if (32'(count_ff) > 32'(MAX_NODES - 1)) lim = 7'(MAX_NODES - 1);
      else lim = count_ff;
   end

   // load decode
   logic is_node, is_edge, is_clear, node_ok, edge_ok, want_edge, full;
   logic [ETW-1:0] total_ff;
   logic           ovf_ff;

   assign is_node   = cmd.load && (req_payload.req_type == lwsp_pkg::KIND_NODE);
   assign is_edge   = cmd.load && (req_payload.req_type == lwsp_pkg::KIND_EDGE);
   assign is_clear  = cmd.load && (req_payload.req_type == lwsp_pkg::KIND_CLEAR);
   assign node_ok   = is_node && (req_payload.node_index != 7'd0)
                      && (req_payload.node_index <= lim);
   assign edge_ok   = is_edge && (req_payload.node_index <= lim)
                      && (req_payload.from_node <= lim);
   assign want_edge = node_ok || edge_ok;
   assign full      = (total_ff == ETW'(MAX_EDGES));

   // edge count and overflow flag
   always_ff @(posedge clock) begin
      if (reset || is_clear) begin
         total_ff <= '0;
         ovf_ff   <= 1'b0;
      end else if (want_edge) begin
         if (full) ovf_ff <= 1'b1;
         else total_ff <= total_ff + ETW'(1);
      end
   end

   // edge store: source, target, weight
   logic [29:0] edge_mem [MAX_EDGES];
   logic [29:0] edge_q_ff;
   logic [ETW-1:0] e_ff;

   always_ff @(posedge clock) begin
      if (want_edge && !full) begin
         edge_mem[EW'(total_ff)] <= {(node_ok ? 7'd0 : req_payload.from_node),
                                     req_payload.node_index, req_payload.cost};
      end
      if (cmd.edge_rd) edge_q_ff <= edge_mem[EW'(e_ff)];
   end

   logic [6:0]  e_src, e_tgt;
   logic [15:0] e_wt;
   assign e_src = edge_q_ff[29:23];
   assign e_tgt = edge_q_ff[22:16];
   assign e_wt  = edge_q_ff[15:0];

   // node levels, with valid bits for the cleared state
   logic [15:0]          lvl_mem [MAX_NODES];
   logic [MAX_NODES-1:0] lvl_vld_ff;
   logic [15:0]          lvl_q_ff;
   logic                 lvl_qv_ff;
   logic [6:0]           lvl_addr;
   logic [6:0]           vwin_ff;
   logic [15:0]          lvl;

   always_comb begin
      lvl_addr = e_tgt;
      if (cmd.lvl_rd_one) lvl_addr = 7'd1;
      else if (cmd.lvl_rd_win) lvl_addr = vwin_ff;
   end

   always_ff @(posedge clock) begin
      if (node_ok) lvl_mem[NW'(req_payload.node_index)] <= req_payload.node_level;
      lvl_q_ff <= lvl_mem[NW'(lvl_addr)];
   end

   always_ff @(posedge clock) begin
      if (reset || is_clear) begin
         lvl_vld_ff <= '0;
         lvl_qv_ff  <= 1'b0;
      end else begin
         if (node_ok) lvl_vld_ff[NW'(req_payload.node_index)] <= 1'b1;
         lvl_qv_ff <= lvl_vld_ff[NW'(lvl_addr)];
      end
   end

   assign lvl = lvl_qv_ff ? lvl_q_ff : 16'd0;

   // window bounds
   logic [15:0] l1_ff, lo_ff;
   logic [16:0] hi_ff, lvl_top;
   assign lvl_top = {1'b0, lvl} + {1'b0, gap_ff};

   always_ff @(posedge clock) begin
      if (cmd.l1_cap) l1_ff <= lvl;
      if (cmd.win_start) begin
         lo_ff <= lvl;
         hi_ff <= lvl_top;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vwin_ff <= 7'd1;
      end else if (cmd.l1_cap) begin
         vwin_ff <= 7'd1;
      end else if (cmd.win_next) begin
         vwin_ff <= vwin_ff + 7'd1;
      end
   end

   // node counter for init and scan passes
   logic [6:0] cnt_ff;
   logic       cnt_last;
   assign cnt_last = (cnt_ff == lim);

   always_ff @(posedge clock) begin
      if (reset || cmd.win_start) begin
         cnt_ff <= '0;
      end else if (cmd.init_wr || cmd.scan_rd) begin
         cnt_ff <= cnt_last ? 7'd0 : cnt_ff + 7'd1;
      end
   end

   // settled flags
   logic [MAX_NODES-1:0] settled_ff;
   logic [6:0]           u_ff;
   always_ff @(posedge clock) begin
      if (reset || is_clear || cmd.win_start) begin
         settled_ff <= '0;
      end else if (cmd.settle) begin
         settled_ff[NW'(u_ff)] <= 1'b1;
      end
   end

   // distance memory
   logic [31:0] dist_mem [MAX_NODES];
   logic [31:0] dist_q_ff;
   logic [6:0]  dist_raddr;
   logic        dist_we;
   logic [6:0]  dist_waddr;
   logic [31:0] dist_wdata;
   logic [32:0] nd_sum;
   logic [31:0] nd;
   logic        edge_hit_ff, upd_ok;
   logic [31:0] du_ff;

   assign nd_sum = {1'b0, du_ff} + {17'd0, e_wt};
   assign nd     = nd_sum[32] ? lwsp_pkg::DIST_INF : nd_sum[31:0];
   assign upd_ok = edge_hit_ff && ({1'b0, lvl} <= hi_ff) && (lvl >= lo_ff)
                   && (nd < dist_q_ff);

   always_comb begin
      dist_raddr = cnt_ff;
      if (cmd.edge_look) dist_raddr = e_tgt;
      else if (cmd.res_rd) dist_raddr = 7'd1;
      dist_we    = cmd.init_wr || (cmd.edge_upd && upd_ok);
      dist_waddr = cmd.init_wr ? cnt_ff : e_tgt;
      dist_wdata = nd;
      if (cmd.init_wr) dist_wdata = (cnt_ff == 7'd0) ? 32'd0 : lwsp_pkg::DIST_INF;
   end

   always_ff @(posedge clock) begin
      if (dist_we) dist_mem[NW'(dist_waddr)] <= dist_wdata;
      dist_q_ff <= dist_mem[NW'(dist_raddr)];
   end

   always_ff @(posedge clock) begin
      if (cmd.edge_look) edge_hit_ff <= (e_src == u_ff) && (e_tgt <= lim);
   end

   // minimum scan, in the cycle after each read
   logic       pend_ff, pend_set_ff, found_ff;
   logic [6:0] pend_idx_ff;
   logic       take;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= cmd.scan_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_rd) begin
         pend_idx_ff <= cnt_ff;
         pend_set_ff <= settled_ff[NW'(cnt_ff)];
      end
   end

   assign take = pend_ff && !pend_set_ff && (dist_q_ff != lwsp_pkg::DIST_INF)
                 && (!found_ff || (dist_q_ff < du_ff));

   always_ff @(posedge clock) begin
      if (reset || cmd.win_start || cmd.settle) begin
         found_ff <= 1'b0;
      end else if (take) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         u_ff  <= pend_idx_ff;
         du_ff <= dist_q_ff;
      end
   end

   // edge walk counter
   always_ff @(posedge clock) begin
      if (reset || cmd.settle) begin
         e_ff <= '0;
      end else if (cmd.edge_upd) begin
         e_ff <= e_ff + ETW'(1);
      end
   end

   // best result over windows
   logic [31:0] best_ff;
   always_ff @(posedge clock) begin
      if (cmd.best_init) begin
         best_ff <= lwsp_pkg::DIST_INF;
      end else if (cmd.res_cap && (dist_q_ff < best_ff)) begin
         best_ff <= dist_q_ff;
      end
   end

   // output register
   logic rsp_valid_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_payload.min_cost <= best_ff;
         rsp_payload.overflow <= ovf_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // status
   always_comb begin
      status.is_solve  = (req_payload.req_type == lwsp_pkg::KIND_SOLVE);
      status.lim_zero  = (lim == 7'd0);
      status.win_ok    = (lvl <= l1_ff) && (lvl_top >= {1'b0, l1_ff});
      status.cnt_last  = cnt_last;
      status.found     = found_ff;
      status.edge_none = (total_ff == '0);
      status.edge_last = ((e_ff + ETW'(1)) == total_ff);
      status.win_last  = (vwin_ff == lim);
      status.rsp_free  = !rsp_valid_ff || !rsp_stall;
   end

endmodule

`default_nettype wire

### sv/level_window_shortest_path.sv
// ----------------------------------------------------------------------------
// level_window_shortest_path
// Least-cost path to node 1 over all level windows, array-scan search.
// ----------------------------------------------------------------------------
//  channel   signals                                  direction
//  req       req_valid, req_stall, req_payload        in (stall out)
//  rsp       rsp_valid, rsp_stall, rsp_payload        out (stall in)
//  csr       csr_valid, csr_ready, csr_index, csr_data in (ready out)
//
//  Load and clear requests are taken back to back while no solve is busy.
//  A solve reads node 1's level, then tests each window in turn; a
//  qualifying window adds an init pass over nodes 0 to L, a scan pass per
//  settled node plus a walk over every stored edge, a final scan and a
//  fold of its result into the best (L = node limit).
//  Synchronous active-high reset; the request side stalls during a solve
//  and while a finished result waits behind a stalled response.
// ----------------------------------------------------------------------------
`default_nettype none

module level_window_shortest_path #(
   parameter int MAX_NODES = 128,
   parameter int MAX_EDGES = 1024
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_stall,
   input  wire lwsp_pkg::req_payload_type req_payload,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output lwsp_pkg::rsp_payload_type  rsp_payload,
   input  wire                        csr_valid,
   output logic                       csr_ready,
   input  wire                        csr_index,
   input  wire  [15:0]                csr_data
);

   lwsp_pkg::cmd_type    cmd;
   lwsp_pkg::status_type status;

   assign csr_ready = 1'b1;

   lwsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lwsp_datapath #(
      .MAX_NODES (MAX_NODES),
      .MAX_EDGES (MAX_EDGES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

### tb/sv/tb_level_window_shortest_path.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_level_window_shortest_path
// Self-checking bench for the level window shortest path block: directed
// graph cases, back-pressure and random graphs under three idling patterns.
// Each solve result is compared with a local predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_level_window_shortest_path;

   localparam int NODES      = 128;
   localparam int EDGES      = 1024;
   localparam int CYCLE_CAP  = 20_000_000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   lwsp_pkg::req_payload_type req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   lwsp_pkg::rsp_payload_type rsp_payload;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic                      csr_index = 1'b0;
   logic [15:0]               csr_data = '0;

   level_window_shortest_path DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // shadow graph
   logic [6:0]      g_src [EDGES];
   logic [6:0]      g_dst [EDGES];
   logic [15:0]     g_wt  [EDGES];
   int              g_edges;
   logic [15:0]     g_level [NODES];
   logic            g_overflow;
   logic [15:0]     g_gap;
   logic [6:0]      g_count;

   lwsp_pkg::rsp_payload_type pending_costs[$];
   int              errors;
   int              requests_sent;
   int              solves_checked;
   longint          cycles;
   int              send_idle_pct;
   int              stall_pct;
   int              hold_cycles;

   // clock
   initial begin
      forever #1 clock = ~clock;
   end

   // ----- predictor ---------------------------------------------------------
   function automatic logic [31:0] window_distance(logic [31:0] lo, logic [31:0] hi, int lim);
      logic [31:0] path_len [NODES];
      logic        done [NODES];
      int          u;
      logic [31:0] du;
      logic        found;
      logic [32:0] nd;
      for (int v = 0; v <= lim; v++) begin
         path_len[v] = lwsp_pkg::DIST_INF;
         done[v] = 1'b0;
      end
      path_len[0] = '0;
      for (int k = 0; k <= lim; k++) begin
         found = 1'b0;
         u = 0;
         du = lwsp_pkg::DIST_INF;
         for (int v = 0; v <= lim; v++) begin
            if (!done[v] && path_len[v] != lwsp_pkg::DIST_INF
                && (!found || path_len[v] < du)) begin
               u = v;
               du = path_len[v];
               found = 1'b1;
            end
         end
         if (!found) break;
         done[u] = 1'b1;
         for (int e = 0; e < g_edges; e++) begin
            if (g_src[e] != u || g_dst[e] > lim) continue;
            if (g_level[g_dst[e]] < lo || g_level[g_dst[e]] > hi) continue;
            nd = {1'b0, du} + {17'd0, g_wt[e]};
            if (nd[32]) nd = {1'b0, lwsp_pkg::DIST_INF};
            if (nd[31:0] < path_len[g_dst[e]]) path_len[g_dst[e]] = nd[31:0];
         end
      end
      return (lim >= 1) ? path_len[1] : lwsp_pkg::DIST_INF;
   endfunction

   function automatic logic [31:0] cheapest_path();
      int          lim;
      logic [31:0] best, lv, l1, d;
      lim  = (g_count > NODES - 1) ? NODES - 1 : g_count;
      best = lwsp_pkg::DIST_INF;
      l1   = 32'(g_level[1]);
      if (lim >= 1) begin
         for (int v = 1; v <= lim; v++) begin
            lv = 32'(g_level[v]);
            if (lv > l1 || lv + 32'(g_gap) < l1) continue;
            d = window_distance(lv, lv + 32'(g_gap), lim);
            if (d < best) best = d;
         end
      end
      return best;
   endfunction

   function automatic void store_edge(logic [6:0] s, logic [6:0] t, logic [15:0] w);
      if (g_edges >= EDGES) begin
         g_overflow = 1'b1;
      end else begin
         g_src[g_edges] = s;
         g_dst[g_edges] = t;
         g_wt[g_edges]  = w;
         g_edges++;
      end
   endfunction

   function automatic void clear_shadow();
      g_edges = 0;
      g_overflow = 1'b0;
      foreach (g_level[i]) g_level[i] = '0;
   endfunction

   // queue an expected result at the tail
   function automatic void add_expected(lwsp_pkg::rsp_payload_type r);
      pending_costs.insert(pending_costs.size(), r);
   endfunction

   function automatic void apply_request(lwsp_pkg::req_payload_type r);
      int lim;
      lim = (g_count > NODES - 1) ? NODES - 1 : g_count;
      case (r.req_type)
         lwsp_pkg::KIND_NODE: begin
            if (r.node_index >= 1 && r.node_index <= lim) begin
               g_level[r.node_index] = r.node_level;
               store_edge(7'd0, r.node_index, r.cost);
            end
         end
         lwsp_pkg::KIND_EDGE: begin
            if (r.node_index <= lim && r.from_node <= lim)
               store_edge(r.from_node, r.node_index, r.cost);
         end
         lwsp_pkg::KIND_CLEAR: clear_shadow();
         default: begin
            add_expected(lwsp_pkg::rsp_payload_type'{min_cost: cheapest_path(),
                                                     overflow: g_overflow});
         end
      endcase
   endfunction

   // ----- drivers -----------------------------------------------------------
   // one request; valid is left high so the next one can follow directly
   task automatic send_request(logic [1:0] kind, logic [6:0] idx, logic [6:0] from,
                               logic [15:0] lvl, logic [15:0] cst);
      lwsp_pkg::req_payload_type r;
      r = '{req_type: kind, node_index: idx, from_node: from, node_level: lvl, cost: cst};
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      apply_request(r);
      requests_sent++;
   endtask

   task automatic idle_sender(int n);
      repeat (n) begin
         @(negedge clock);
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic paced_request(logic [1:0] kind, logic [6:0] idx, logic [6:0] from,
                                logic [15:0] lvl, logic [15:0] cst);
      while ($urandom_range(99) < send_idle_pct) idle_sender(1);
      send_request(kind, idx, from, lvl, cst);
   endtask

   // wait for all results, then let a trailing load retire
   task automatic drain();
      idle_sender(1);
      while (pending_costs.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == lwsp_pkg::CSR_LEVEL_GAP) g_gap = value;
      else g_count = value[6:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(logic [15:0] gap, logic [6:0] count);
      drain();
      write_csr(lwsp_pkg::CSR_LEVEL_GAP, gap);
      write_csr(lwsp_pkg::CSR_NODE_COUNT, {9'd0, count});
   endtask

   // ----- response side -----------------------------------------------------
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   always @(posedge clock) begin
      lwsp_pkg::rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_costs.size() == 0) begin
            report_mismatch("unexpected result", rsp_payload.min_cost, 32'd0);
         end else begin
            want = pending_costs.pop_front();
            if (rsp_payload.min_cost != want.min_cost)
               report_mismatch("min_cost", rsp_payload.min_cost, want.min_cost);
            if (rsp_payload.overflow != want.overflow)
               report_mismatch("overflow", 32'(rsp_payload.overflow), 32'(want.overflow));
            solves_checked++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ----- tests -------------------------------------------------------------
   task automatic test_defaults();
      // empty graph straight out of reset, then node_count of one
      send_request(lwsp_pkg::KIND_SOLVE, 0, 0, 0, 0);
      send_request(lwsp_pkg::KIND_NODE, 1, 0, 16'hFFFF, 16'd7);
      send_request(lwsp_pkg::KIND_SOLVE, 0, 0, 0, 0);
   endtask

   task automatic test_small_graph();
      configure(16'd0, 7'd4);
      send_request(lwsp_pkg::KIND_NODE, 0, 0, 5, 1);          // source node, ignored
      send_request(lwsp_pkg::KIND_NODE, 5, 0, 0, 1);          // above the limit
      send_request(lwsp_pkg::KIND_NODE, 2, 0, 3, 10);
      send_request(lwsp_pkg::KIND_NODE, 3, 0, 3, 2);
      send_request(lwsp_pkg::KIND_NODE, 1, 0, 3, 16'hFFFF);
      send_request(lwsp_pkg::KIND_EDGE, 1, 2, 0, 5);
      send_request(lwsp_pkg::KIND_EDGE, 2, 3, 0, 1);
      send_request(lwsp_pkg::KIND_EDGE, 1, 7'h7F, 0, 0);      // source above the limit
      send_request(lwsp_pkg::KIND_SOLVE, 0, 0, 0, 0);
      send_request(lwsp_pkg::KIND_NODE, 3, 0, 9, 1);          // repeated record, new level
      send_request(lwsp_pkg::KIND_SOLVE, 0, 0, 0, 0);
      configure(16'hFFFF, 7'd4);
      send_request(lwsp_pkg::KIND_SOLVE, 0, 0, 0, 0);
      configure(16'd6, 7'd2);                        // edges of node 3 now ignored
      send_request(lwsp_pkg::KIND_SOLVE, 0, 0, 0, 0);
      send_request(lwsp_pkg::KIND_CLEAR, 0, 0, 0, 0);
      send_request(lwsp_pkg::KIND_SOLVE, 0, 0, 0, 0);
   endtask

   task automatic test_widest_graph();
      configure(16'd1, 7'd127);
      send_request(lwsp_pkg::KIND_NODE, 7'd127, 0, 16'd0, 16'd3);
      send_request(lwsp_pkg::KIND_EDGE, 7'd1, 7'd127, 16'd0, 16'hFFFF);
      send_request(lwsp_pkg::KIND_NODE, 7'd1, 0, 16'd1, 16'hFFFF);
      send_request(lwsp_pkg::KIND_SOLVE, 0, 0, 0, 0);
      send_request(lwsp_pkg::KIND_CLEAR, 0, 0, 0, 0);
   endtask

   // receiver holds off while requests keep coming, then the sender waits
   task automatic test_backpressure();
      configure(16'd2, 7'd4);
      fork
         hold_cycles = 400;
         begin
            send_request(lwsp_pkg::KIND_NODE, 1, 0, 1, 4);
            send_request(lwsp_pkg::KIND_SOLVE, 0, 0, 0, 0);
            for (int i = 0; i < 12; i++)
               send_request(lwsp_pkg::KIND_EDGE, 7'($urandom_range(1, 4)),
                            7'($urandom_range(0, 4)), 0, 16'($urandom_range(0, 20)));
            send_request(lwsp_pkg::KIND_SOLVE, 0, 0, 0, 0);
         end
      join
      drain();
      send_request(lwsp_pkg::KIND_SOLVE, 0, 0, 0, 0);
      send_request(lwsp_pkg::KIND_CLEAR, 0, 0, 0, 0);
   endtask

   task automatic random_request(int count);
      int          pick;
      logic [1:0]  kind;
      logic [6:0]  idx, from;
      logic [15:0] lvl, cst;
      pick = $urandom_range(99);
      if (pick < 42)      kind = lwsp_pkg::KIND_NODE;
      else if (pick < 88) kind = lwsp_pkg::KIND_EDGE;
      else if (pick < 96) kind = lwsp_pkg::KIND_SOLVE;
      else                kind = lwsp_pkg::KIND_CLEAR;
      // mostly real nodes, sometimes any index
      if ($urandom_range(9) == 0) begin
         idx  = 7'($urandom);
         from = 7'($urandom);
      end else begin
         idx  = 7'($urandom_range(0, count + 1));
         from = 7'($urandom_range(0, count));
      end
      lvl = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
      cst = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
      paced_request(kind, idx, from, lvl, cst);
   endtask

   task automatic test_random_phase(int sender_idle, int receiver_idle, int n);
      logic [6:0] count;
      send_idle_pct = sender_idle;
      stall_pct     = receiver_idle;
      for (int i = 0; i < n; i++) begin
         if (i % 80 == 0) begin
            count = 7'($urandom_range(2, 8));
            configure(($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4)),
                      count);
            send_request(lwsp_pkg::KIND_CLEAR, 0, 0, 0, 0);
         end
         random_request(count);
      end
      drain();
   endtask

   // ----- sequence ----------------------------------------------------------
   initial begin
      errors = 0;
      requests_sent = 0;
      solves_checked = 0;
      cycles = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      hold_cycles = 0;
      g_gap = '0;
      g_count = 7'd1;
      clear_shadow();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_defaults();
      test_small_graph();
      test_widest_graph();
      test_backpressure();
      test_random_phase(12, 76, 210);
      test_random_phase(76, 12, 210);
      test_random_phase(0, 0, 210);
      drain();
      repeat (20) @(posedge clock);

      $display("covered: %0d requests, %0d solve results, directed graphs and stalls",
               requests_sent, solves_checked);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

### sim.f
sv/lwsp_pkg.sv
sv/lwsp_ctrl.sv
sv/lwsp_datapath.sv
sv/level_window_shortest_path.sv
tb/sv/tb_level_window_shortest_path.sv
